/* sv/asr_pkg.sv */
`default_nettype none

package asr_pkg;

    // saturation limits applied to the incoming box size
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_WIDTH  = 1023;

    // serial divider geometry: dividend bits and divisor bits
    localparam int DIV_W   = 15;
    localparam int DVSR_W  = 7;
    localparam int CNT_W   = 4;

    // pointing directions
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // request to the serial divider
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    // status back from the serial divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/asr_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module asr_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire asr_pkg::div_req_t req,
    output asr_pkg::div_rsp_t      rsp
);

    logic [asr_pkg::DVSR_W-1:0] rem_reg, rem_next;
    logic [asr_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [asr_pkg::DVSR_W-1:0] dvsr_reg;
    logic [asr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [asr_pkg::DVSR_W:0]   shifted;
    logic                       ge;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, quo_reg[asr_pkg::DIV_W-1]};
    assign ge      = (shifted >= {1'b0, dvsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = asr_pkg::CNT_W'(asr_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? asr_pkg::DVSR_W'(shifted - {1'b0, dvsr_reg})
                          : shifted[asr_pkg::DVSR_W-1:0];
            quo_next = {quo_reg[asr_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == asr_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dvsr_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with empty step count");
`endif

endmodule

`default_nettype wire

/* sv/arrow_span_rasterizer.sv */
// Sequence: after a request is taken there is one setup state, then per row a
// multiply state, a divide state that waits for the 15 serial divider steps and
// their done flag, and an emit state that presents the span when the output can.
// A new request is taken only after the last row's span is loaded, rows up to 64;
// an output stall holds the emit state. An empty box frees the input at once.
// Reset: rst_n is asynchronous, active low; clears sequencer, row counter, out valid.
`default_nettype none

module arrow_span_rasterizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_axis_tdata: pos_x[15:0], pos_y[31:16], box_width[41:32], box_height[48:42],
    //               direction[50:49], trianglify[51], fill_color[75:52], zero pad
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,
    // m_axis_tdata: span_x[15:0], span_y[31:16], span_len[42:32],
    //               span_color[66:43], zero pad; m_axis_tlast: last_span
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [5:0]      row_reg, row_next;
    logic [15:0]     x_reg, x_next;
    logic [15:0]     y_reg, y_next;
    logic [9:0]      w_reg, w_next;
    logic [6:0]      h_reg, h_next;
    asr_pkg::dir_t   dir_reg, dir_next;
    logic            tri_reg, tri_next;
    logic [23:0]     color_reg, color_next;
    logic            m_valid_reg, m_valid_next;
    logic [71:0]     m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;

    // request fields
    logic [15:0]     in_x, in_y;
    logic [9:0]      in_w, in_w_sat;
    logic [6:0]      in_h, in_h_sat;
    logic [23:0]     in_color;
    logic            accept;

    // setup
    logic [10:0]     want_v_sum;
    logic [9:0]      want_v;
    logic [7:0]      want_h_sum;
    logic [6:0]      want_h;
    logic [15:0]     tx, ty;
    logic [9:0]      tw;
    logic [6:0]      th;

    // per-row arithmetic
    logic            vert;
    logic [5:0]      half;
    logic            second_half;
    logic [6:0]      idx_v;
    logic [5:0]      mul_a;
    logic [9:0]      mul_b;
    logic [15:0]     product;
    logic [9:0]      quo;
    logic [9:0]      beg_lr, beg_x;
    logic [10:0]     span_len;
    logic            last_row;
    logic            load_out;

    asr_pkg::div_req_t div_req;
    asr_pkg::div_rsp_t div_rsp;

    assign in_x     = s_axis_tdata[15:0];
    assign in_y     = s_axis_tdata[31:16];
    assign in_w     = s_axis_tdata[41:32];
    assign in_h     = s_axis_tdata[48:42];
    assign in_color = s_axis_tdata[75:52];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // saturate box size
    assign in_w_sat = (32'(in_w) > asr_pkg::MAX_WIDTH)  ? 10'(asr_pkg::MAX_WIDTH)  : in_w;
    assign in_h_sat = (32'(in_h) > asr_pkg::MAX_HEIGHT) ? 7'(asr_pkg::MAX_HEIGHT) : in_h;

    // trianglify narrowing and evening of the box
    assign want_v_sum = {1'b0, w_reg} + 11'd1;
    assign want_v     = want_v_sum[10:1];
    assign want_h_sum = {1'b0, h_reg} + 8'd1;
    assign want_h     = want_h_sum[7:1];

    always_comb
    begin
        tx = x_reg;
        ty = y_reg;
        tw = w_reg;
        th = h_reg;
        if (tri_reg)
        begin
            if (!dir_reg[1])
            begin
                if (want_v < {3'b000, h_reg})
                begin
                    ty = y_reg + {10'd0, 6'((h_reg - want_v[6:0]) >> 1)};
                    th = want_v[6:0];
                end
            end
            else if ({3'b000, want_h} < w_reg)
            begin
                tx = x_reg + {7'd0, 9'((w_reg - {3'b000, want_h}) >> 1)};
                tw = {3'b000, want_h};
            end
        end
        tw = tw & ~10'd1;
        th = th & ~7'd1;
    end

    // multiplier operands for the current row
    assign vert        = !dir_reg[1];
    assign half        = h_reg[6:1];
    assign second_half = (row_reg >= half);
    assign idx_v       = (dir_reg == asr_pkg::DIR_UP) ? (h_reg - 7'd1 - {1'b0, row_reg})
                                                    : {1'b0, row_reg};
    assign mul_a       = vert ? idx_v[5:0] : (second_half ? (row_reg - half) : row_reg);
    assign mul_b       = vert ? {1'b0, w_reg[9:1]} : w_reg;
    assign product     = mul_a * mul_b;

    assign div_req.start    = (state_reg == ST_MUL);
    assign div_req.dividend = product[asr_pkg::DIV_W-1:0];
    assign div_req.divisor  = vert ? h_reg : {1'b0, half};

    asr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // span from the quotient
    assign quo    = div_rsp.quotient[9:0];
    assign beg_lr = second_half ? quo : (w_reg - quo);

    always_comb
    begin
        unique case (dir_reg)
            asr_pkg::DIR_UP, asr_pkg::DIR_DOWN:
            begin
                beg_x    = quo;
                span_len = {1'b0, w_reg} - {quo, 1'b0} - 11'd1;
            end
            asr_pkg::DIR_LEFT:
            begin
                beg_x    = beg_lr;
                span_len = {1'b0, w_reg} - 11'd1 - {1'b0, beg_lr};
            end
            default:
            begin
                beg_x    = 10'd1;
                span_len = {1'b0, w_reg} - 11'd1 - {1'b0, beg_lr};
            end
        endcase
    end

    assign last_row = ({1'b0, row_reg} == (h_reg - 7'd1));
    assign load_out = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        dir_next     = dir_reg;
        tri_next     = tri_reg;
        color_next   = color_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = in_x;
                    y_next     = in_y;
                    w_next     = in_w_sat;
                    h_next     = in_h_sat;
                    dir_next   = asr_pkg::dir_t'(s_axis_tdata[50:49]);
                    tri_next   = s_axis_tdata[51];
                    color_next = in_color;
                    if ((in_w_sat != '0) && (in_h_sat != '0))
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                x_next   = tx;
                y_next   = ty;
                w_next   = tw;
                h_next   = th;
                row_next = '0;
                state_next = (th == '0) ? ST_IDLE : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, color_reg, span_len,
                                    y_reg + {10'd0, row_reg},
                                    x_reg + {6'd0, beg_x}};
                    m_last_next  = last_row;
                    if (last_row)
                    begin
                        state_next = ST_IDLE;
                        row_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        row_next   = row_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and output payload
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        dir_reg    <= dir_next;
        tri_reg    <= tri_next;
        color_reg  <= color_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_w_sat != '0) && (in_h_sat != '0)) |=> !s_axis_tready)
        else $error("input ready right after taking a non-empty request");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending span overwritten");
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> ({1'b0, row_reg} < h_reg))
        else $error("row beyond box height");
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire
